// ----- hdl/msl_pkg.sv -----
`default_nettype none

package msl_pkg;

  localparam int DW      = 32;
  localparam int FRAC    = 16;
  localparam int NCOMP   = 3;
  localparam int MAX_DIM = 3;

  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int PADDR_W = 3;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_MINMOD = 2'd1;
  localparam logic [1:0] MODE_MUSCL  = 2'd2;

  localparam logic [1:0] MODE_RESET = MODE_MINMOD;
  localparam logic [1:0] DIM_RESET  = 2'd3;

  // register index = paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIM  = 1'b1;

  localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

  typedef logic signed [DW-1:0] data_t;

endpackage

`default_nettype wire

// ----- hdl/msl_in_if.sv -----
`default_nettype none

interface msl_in_if;
  import msl_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  data_t average;
  data_t vec_x;
  data_t vec_y;
  data_t vec_z;
  logic  last;

  modport source (output valid, func, average, vec_x, vec_y, vec_z, last, input ready);
  modport sink   (input valid, func, average, vec_x, vec_y, vec_z, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/msl_out_if.sv -----
`default_nettype none

interface msl_out_if;
  import msl_pkg::*;

  logic  valid;
  logic  ready;
  data_t slope_x;
  data_t slope_y;
  data_t slope_z;
  logic  zero_distance_seen;

  modport source (output valid, slope_x, slope_y, slope_z, zero_distance_seen, input ready);
  modport sink   (input valid, slope_x, slope_y, slope_z, zero_distance_seen, output ready);
endinterface

`default_nettype wire

// ----- hdl/minmod_slope_limiter_top.sv -----
// Minmod slope limiter, Q16.16.
// in_chan (valid/ready): a cell item (func=0) loads the cell average and the
// gradient; neighbor items (func=1) in minmod or MUSCL mode each fold one
// neighbor slope into the running per-component minimum and maximum. An item
// with last=1 produces one transfer on out_chan: the componentwise minmod, plus
// a flag telling whether a neighbor with zero distance was skipped.
// Sequencing: a cell item is taken in the idle state; a neighbor item in
// minmod or MUSCL mode runs SQ and ACC per component, CHK, the 32-step
// radix-2 divider (DIV, then CAP), then MUL and UPD per component, using the
// single shared 32x32 multiplier for |r|^2 and for q*r. A zero-distance
// neighbor ends after CHK; one whose quotient saturates skips the divider.
// Linear mode neighbors are taken in idle. An item with last=1 then loads the
// output register. in_ready is high only in idle with no output load pending.
// The output register decouples the sides: the next item is taken while a
// result waits. If a new result is ready while the old one is still stalled,
// the sequencer holds until out_chan.ready takes the old one.
// Config (APB): reg 0 limiter_mode at 0x0, reg 1 dimension at 0x4; write
// only while idle. Reset (rst_n low, synchronous) clears the held state,
// sets mode to minmod and dimension to 3, and drops out_chan.valid.
`default_nettype none

module minmod_slope_limiter_top
  import msl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  msl_in_if.sink                  in_chan,
  msl_out_if.source               out_chan,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQ   = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_CAP  = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_UPD  = 8'b1000_0000
  } state_t;

  // output load is tracked by a flag of its own, outside the state encoding
  logic out_pend_r, out_pend_nxt;

  state_t state_r, state_nxt;

  logic [1:0] mode_r, dimension_r;

  data_t            avg_r, avg_nxt;
  data_t            min_r [NCOMP], min_nxt [NCOMP];
  data_t            max_r [NCOMP], max_nxt [NCOMP];
  logic             flag_r, flag_nxt;
  logic [DW-1:0]    mag_r [NCOMP], mag_nxt [NCOMP];
  logic             vneg_r [NCOMP], vneg_nxt [NCOMP];
  logic             neg_r, neg_nxt;
  logic [DW+1:0]    m_r, m_nxt;
  logic             last_r, last_nxt;
  logic [1:0]       dim_r, dim_nxt;
  logic [1:0]       d_r, d_nxt;
  logic [2*DW-1:0]  nsq_r, nsq_nxt;
  logic [2*DW-1:0]  prod_r, prod_nxt;
  logic [2*DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  data_t         out_s_r [NCOMP], out_s_nxt [NCOMP];
  logic          out_zd_r, out_zd_nxt;

  logic              in_fire, out_load, cfg_wr;
  data_t             vin [NCOMP];
  logic [1:0]        dim_eff;
  logic signed [DW:0] diff;
  logic [DW:0]       diff_mag;
  logic [DW-1:0]     mul_a, mul_b;
  logic [2*DW-1:0]   mul_p;
  logic [2*DW:0]     rem_sh;
  logic [2*DW+1:0]   rem_sub;
  logic [DW-1:0]     cap;
  logic [2*DW-FRAC-1:0] p_sh;
  logic              sneg;
  data_t             s_val;
  logic              last_comp;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {30'd0, mode_r};
      REG_DIM:  prdata = {30'd0, dimension_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE) && !out_pend_r;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid              = out_valid_r;
  assign out_chan.slope_x            = out_s_r[0];
  assign out_chan.slope_y            = out_s_r[1];
  assign out_chan.slope_z            = out_s_r[2];
  assign out_chan.zero_distance_seen = out_zd_r;

  assign vin[0] = in_chan.vec_x;
  assign vin[1] = in_chan.vec_y;
  assign vin[2] = in_chan.vec_z;

  always_comb begin
    if (dimension_r == 2'd0) begin
      dim_eff = 2'd1;
    end else if (32'(dimension_r) > MAX_DIM) begin
      dim_eff = 2'(MAX_DIM);
    end else begin
      dim_eff = dimension_r;
    end
  end

  assign diff     = {in_chan.average[DW-1], in_chan.average} - {avg_r[DW-1], avg_r};
  assign diff_mag = diff[DW] ? (DW+1)'(-diff) : diff;

  // shared multiplier: squares during SQ, q * |r_d| during MUL
  assign mul_a = (state_r == S_MUL) ? quo_r : mag_r[d_r];
  assign mul_b = mag_r[d_r];
  assign mul_p = mul_a * mul_b;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, nsq_r};
  assign cap     = neg_r ? SAT_NEG : SAT_POS;

  assign p_sh  = prod_r[2*DW-1:FRAC];
  assign sneg  = neg_r ^ vneg_r[d_r];
  always_comb begin
    if (!sneg) begin
      s_val = (|p_sh[2*DW-FRAC-1:DW-1]) ? SAT_POS : data_t'(p_sh[DW-1:0]);
    end else begin
      s_val = (|p_sh[2*DW-FRAC-1:DW-1]) ? SAT_NEG : data_t'(-p_sh[DW-1:0]);
    end
  end

  assign last_comp = (d_r == 2'(dim_r - 2'd1));
  assign out_load  = out_pend_r && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt    = state_r;
    out_pend_nxt = out_pend_r;
    avg_nxt      = avg_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    flag_nxt     = flag_r;
    mag_nxt      = mag_r;
    vneg_nxt     = vneg_r;
    neg_nxt      = neg_r;
    m_nxt        = m_r;
    last_nxt     = last_r;
    dim_nxt      = dim_r;
    d_nxt        = d_r;
    nsq_nxt      = nsq_r;
    prod_nxt     = prod_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    out_s_nxt    = out_s_r;
    out_zd_nxt   = out_zd_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      for (int d = 0; d < NCOMP; d++) begin
        if (d < 32'(dim_r) && min_r[d] > 0) begin
          out_s_nxt[d] = min_r[d];
        end else if (d < 32'(dim_r) && max_r[d] < 0) begin
          out_s_nxt[d] = max_r[d];
        end else begin
          out_s_nxt[d] = '0;
        end
      end
      out_zd_nxt    = flag_r;
      out_valid_nxt = 1'b1;
      out_pend_nxt  = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_chan.last;
          dim_nxt  = dim_eff;
          if (!in_chan.func) begin
            avg_nxt = in_chan.average;
            for (int d = 0; d < NCOMP; d++) begin
              min_nxt[d] = (d < 32'(dim_eff)) ? vin[d] : '0;
              max_nxt[d] = (d < 32'(dim_eff)) ? vin[d] : '0;
            end
            flag_nxt     = 1'b0;
            out_pend_nxt = in_chan.last;
          end else if (mode_r == MODE_MINMOD || mode_r == MODE_MUSCL) begin
            for (int d = 0; d < NCOMP; d++) begin
              vneg_nxt[d] = vin[d][DW-1];
              mag_nxt[d]  = vin[d][DW-1] ? DW'(-vin[d]) : vin[d];
            end
            neg_nxt   = diff[DW];
            m_nxt     = (mode_r == MODE_MINMOD) ? {diff_mag, 1'b0} : {1'b0, diff_mag};
            nsq_nxt   = '0;
            d_nxt     = 2'd0;
            state_nxt = S_SQ;
          end else begin
            out_pend_nxt = in_chan.last;
          end
        end
      end
      S_SQ: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        nsq_nxt = nsq_r + prod_r;
        if (last_comp) begin
          state_nxt = S_CHK;
        end else begin
          d_nxt     = d_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_CHK: begin
        if (nsq_r == '0) begin
          flag_nxt     = 1'b1;
          out_pend_nxt = last_r;
          state_nxt    = S_IDLE;
        end else if ({{(DW-2){1'b0}}, m_r} >= nsq_r) begin
          // quotient would reach 2^32
          quo_nxt   = cap;
          d_nxt     = 2'd0;
          state_nxt = S_MUL;
        end else begin
          rem_nxt   = {{(DW-2){1'b0}}, m_r};
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_sub[2*DW+1] ? rem_sh[2*DW-1:0] : rem_sub[2*DW-1:0];
        quo_nxt = {quo_r[DW-2:0], ~rem_sub[2*DW+1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        if (quo_r > cap) begin
          quo_nxt = cap;
        end
        d_nxt     = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (s_val < min_r[d_r]) begin
          min_nxt[d_r] = s_val;
        end
        if (s_val > max_r[d_r]) begin
          max_nxt[d_r] = s_val;
        end
        if (last_comp) begin
          out_pend_nxt = last_r;
          state_nxt    = S_IDLE;
        end else begin
          d_nxt     = d_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_RESET;
      dimension_r <= DIM_RESET;
      avg_r       <= '0;
      flag_r      <= 1'b0;
      for (int d = 0; d < NCOMP; d++) begin
        min_r[d] <= '0;
        max_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_pend_r  <= out_pend_nxt;
      out_valid_r <= out_valid_nxt;
      avg_r       <= avg_nxt;
      flag_r      <= flag_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_MODE: mode_r      <= pwdata[1:0];
          REG_DIM:  dimension_r <= pwdata[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    vneg_r   <= vneg_nxt;
    neg_r    <= neg_nxt;
    m_r      <= m_nxt;
    last_r   <= last_nxt;
    dim_r    <= dim_nxt;
    d_r      <= d_nxt;
    nsq_r    <= nsq_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    out_s_r  <= out_s_nxt;
    out_zd_r <= out_zd_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/msl_checker.sv -----
`default_nettype none

module msl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_func,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready
);

  // a pending result is not dropped while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a closing item always makes the sequencer busy, so the input drops its ready
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready after a closing item");

  // a cell item that does not close the group leaves the input ready in the cycle after it
  a_cell_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func && !in_last |=> in_ready)
    else $error("cell item stalled the input");

  // a new result only appears out of a busy cycle
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a closing item");

endmodule

bind minmod_slope_limiter_top msl_checker u_msl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_func   (in_chan.func),
  .in_last   (in_chan.last),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);

`default_nettype wire
